// ----- rtl/ucp_pkg.sv -----
// Shared types, constants and helpers for the unified camera projection block.
package ucp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 29;
  localparam int XI_W          = 19;
  localparam int IDX_W         = 3;
  localparam int SQ_W          = 64;
  localparam int ROOT_W        = 32;
  localparam int PROD_W        = XI_W + ROOT_W;
  localparam int DEN_W         = PROD_W + 1;
  localparam int NMAG_W        = CFG_W + COORD_W;
  localparam int NUM_W         = NMAG_W + 1;
  localparam int REM_W         = DEN_W + 1;

  localparam int NORM_STAGES   = 2 + ROOT_W;
  localparam int DENOM_STAGES  = 4;
  localparam int DIV_STAGES    = NUM_W;
  localparam int LATENCY       = NORM_STAGES + DENOM_STAGES + DIV_STAGES + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_MIRROR   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_u;
    logic signed [COORD_W-1:0] pixel_v;
    logic                      valid_res;
  } pixel_t;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [XI_W-1:0]  mirror_xi;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic             degen;
    logic [CFG_W-1:0] offset;
  } div_side_t;

  // {saturated, value}: signed rounded quotient plus offset, clamped to 32 bits
  function automatic logic [COORD_W:0] ucp_finish(input logic [NUM_W-1:0] q,
                                                  input logic neg,
                                                  input logic [CFG_W-1:0] off);
    logic signed [63:0] mag;
    logic signed [63:0] val;
    logic               sat;
    logic [COORD_W-1:0] res;
    mag = $signed({{(64-NUM_W){1'b0}}, q});
    val = ((neg && (q != '0)) ? -mag : mag) + $signed({{(64-CFG_W){1'b0}}, off});
    sat = 1'b0;
    res = val[COORD_W-1:0];
    if (val > 64'sd2147483647) begin
      sat = 1'b1;
      res = 32'h7FFF_FFFF;
    end else if (val < -64'sd2147483648) begin
      sat = 1'b1;
      res = 32'h8000_0000;
    end
    return {sat, res};
  endfunction

endpackage

// ----- rtl/ucp_norm.sv -----
// Euclidean norm pipeline: squares, sum, then one integer square root bit per stage.
module ucp_norm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  ucp_pkg::point_t               in_point,
  output logic                          out_valid,
  output ucp_pkg::point_t               out_point,
  output logic [ucp_pkg::ROOT_W-1:0]    out_root
);

  localparam int SQ_W   = ucp_pkg::SQ_W;
  localparam int ROOT_W = ucp_pkg::ROOT_W;

  logic [ucp_pkg::COORD_W-1:0] ax, ay, az;
  logic [SQ_W-1:0]             sqx_r, sqy_r, sqz_r;
  logic                        v0_r;
  ucp_pkg::point_t             pt0_r;

  logic [SQ_W-1:0]             s_r   [0:ROOT_W];
  logic [SQ_W-1:0]             res_r [0:ROOT_W];
  logic                        v_r   [0:ROOT_W];
  ucp_pkg::point_t             pt_r  [0:ROOT_W];

  assign ax = in_point.point_x[31] ? (~in_point.point_x + 1'b1) : in_point.point_x;
  assign ay = in_point.point_y[31] ? (~in_point.point_y + 1'b1) : in_point.point_y;
  assign az = in_point.point_z[31] ? (~in_point.point_z + 1'b1) : in_point.point_z;

  // squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= SQ_W'(ax) * SQ_W'(ax);
    sqy_r <= SQ_W'(ay) * SQ_W'(ay);
    sqz_r <= SQ_W'(az) * SQ_W'(az);
    pt0_r <= in_point;
  end

  // sum of squares (fits 64 bits)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    s_r[0]   <= sqx_r + sqy_r + sqz_r;
    res_r[0] <= '0;
    pt_r[0]  <= pt0_r;
  end

  // digit-by-digit root, bit position fixed per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] s_nxt;
    logic [SQ_W-1:0] res_nxt;

    assign bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    assign trial = res_r[k] + bitv;

    always_comb begin
      if (s_r[k] >= trial) begin
        s_nxt   = s_r[k] - trial;
        res_nxt = (res_r[k] >> 1) + bitv;
      end else begin
        s_nxt   = s_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      s_r[k+1]   <= s_nxt;
      res_r[k+1] <= res_nxt;
      pt_r[k+1]  <= pt_r[k];
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_point = pt_r[ROOT_W];
  assign out_root  = res_r[ROOT_W][ROOT_W-1:0];

endmodule

// ----- rtl/ucp_denom.sv -----
// Denominator xi*d + z, numerator magnitudes and divider operands.
module ucp_denom #(
  parameter int FRAC_BITS = ucp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  ucp_pkg::point_t              in_point,
  input  logic [ucp_pkg::ROOT_W-1:0]   in_root,
  input  ucp_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output logic [ucp_pkg::NUM_W-1:0]    out_num_x,
  output logic [ucp_pkg::NUM_W-1:0]    out_num_y,
  output logic [ucp_pkg::DEN_W-1:0]    out_div,
  output ucp_pkg::div_side_t           out_side_x,
  output ucp_pkg::div_side_t           out_side_y
);

  localparam int PROD_W = ucp_pkg::PROD_W;
  localparam int DEN_W  = ucp_pkg::DEN_W;
  localparam int NMAG_W = ucp_pkg::NMAG_W;
  localparam int NUM_W  = ucp_pkg::NUM_W;
  localparam int CW     = ucp_pkg::COORD_W;

  // stage A: xi * d
  logic                va_r, zr_a_r;
  logic [PROD_W-1:0]   prod_r;
  ucp_pkg::point_t     pa_r;
  // stage B: rounded product plus z
  logic                vb_r, zr_b_r;
  logic signed [DEN_W-1:0] den_r;
  ucp_pkg::point_t     pb_r;
  // stage C: magnitudes and numerator products
  logic                vc_r, degen_c_r, negx_c_r, negy_c_r;
  logic [DEN_W-1:0]    dmag_r;
  logic [NMAG_W-1:0]   nmx_r, nmy_r;
  // stage D: divider operands
  logic                vd_r;

  logic [PROD_W:0]     rnd;
  logic [PROD_W:0]     xd;
  logic [CW-1:0]       bx, by;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  assign rnd = {1'b0, prod_r} + ((PROD_W + 1)'(1) << (FRAC_BITS - 1));
  assign xd  = rnd >> FRAC_BITS;
  assign bx  = pb_r.point_x[CW-1] ? (~pb_r.point_x + 1'b1) : pb_r.point_x;
  assign by  = pb_r.point_y[CW-1] ? (~pb_r.point_y + 1'b1) : pb_r.point_y;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(cfg.mirror_xi) * PROD_W'(in_root);
    pa_r   <= in_point;
    zr_a_r <= (in_root == '0);

    den_r  <= $signed(DEN_W'(xd)) + DEN_W'(pa_r.point_z);
    pb_r   <= pa_r;
    zr_b_r <= zr_a_r;

    dmag_r    <= den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
    nmx_r     <= NMAG_W'(cfg.focal_x) * NMAG_W'(bx);
    nmy_r     <= NMAG_W'(cfg.focal_y) * NMAG_W'(by);
    degen_c_r <= zr_b_r || (den_r == '0);
    negx_c_r  <= pb_r.point_x[CW-1] ^ den_r[DEN_W-1];
    negy_c_r  <= pb_r.point_y[CW-1] ^ den_r[DEN_W-1];

    out_num_x  <= {nmx_r, 1'b0} + NUM_W'(dmag_r);
    out_num_y  <= {nmy_r, 1'b0} + NUM_W'(dmag_r);
    out_div    <= {dmag_r[DEN_W-2:0], 1'b0};
    out_side_x <= '{neg: negx_c_r, degen: degen_c_r, offset: cfg.center_x};
    out_side_y <= '{neg: negy_c_r, degen: degen_c_r, offset: cfg.center_y};
  end

  assign out_valid = vd_r;

endmodule

// ----- rtl/ucp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module ucp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [ucp_pkg::NUM_W-1:0]   in_num,
  input  logic [ucp_pkg::DEN_W-1:0]   in_div,
  input  ucp_pkg::div_side_t          in_side,
  output logic                        out_valid,
  output logic [ucp_pkg::NUM_W-1:0]   out_quot,
  output ucp_pkg::div_side_t          out_side
);

  localparam int NUM_W = ucp_pkg::NUM_W;
  localparam int DEN_W = ucp_pkg::DEN_W;
  localparam int REM_W = ucp_pkg::REM_W;

  logic                v_r    [1:NUM_W];
  logic [DEN_W-1:0]    rem_r  [1:NUM_W];
  logic [NUM_W-1:0]    num_r  [1:NUM_W];
  logic [NUM_W-1:0]    quot_r [1:NUM_W];
  logic [DEN_W-1:0]    div_r  [1:NUM_W];
  ucp_pkg::div_side_t  side_r [1:NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic               pv;
    logic [DEN_W-1:0]   prem, pdiv;
    logic [NUM_W-1:0]   pnum, pquot;
    ucp_pkg::div_side_t pside;
    logic [REM_W-1:0]   trial;
    logic               take;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign pnum  = in_num;
      assign pquot = '0;
      assign pdiv  = in_div;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[i];
      assign prem  = rem_r[i];
      assign pnum  = num_r[i];
      assign pquot = quot_r[i];
      assign pdiv  = div_r[i];
      assign pside = side_r[i];
    end

    assign trial = {prem, pnum[NUM_W-1]};
    assign take  = trial >= {1'b0, pdiv};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i+1]  <= take ? DEN_W'(trial - {1'b0, pdiv}) : DEN_W'(trial);
      num_r[i+1]  <= {pnum[NUM_W-2:0], 1'b0};
      quot_r[i+1] <= {pquot[NUM_W-2:0], take};
      div_r[i+1]  <= pdiv;
      side_r[i+1] <= pside;
    end
  end

  assign out_valid = v_r[NUM_W];
  assign out_quot  = quot_r[NUM_W];
  assign out_side  = side_r[NUM_W];

endmodule

// ----- rtl/unified_camera_project.sv -----
// Top level of the unified camera model projection pipeline.
//
// Usage:
//  - Input: drive start high with a point (in_point: signed Q16.16 x, y, z).
//    A request is taken at every clock edge where start is high; busy is
//    always low, so a new point can enter on every cycle.
//  - Output: out_strobe is high for one cycle with out_res (pixel_u,
//    pixel_v, valid_res). The receiver cannot hold results off; results
//    come out in request order, one per request.
//  - Stages in order from the accepting edge to the strobe: squares and
//    sum, the square root (one root bit per stage), denominator and
//    numerators, the dividers (one quotient bit per stage), then sign,
//    offset and saturation.
//  - Throughput: one point per cycle, sustained.
//  - Configuration: cfg_we writes cfg_wdata to register cfg_index
//    (0 focal_x, 1 focal_y, 2 center_x, 3 center_y, 4 mirror_xi); unknown
//    indices are ignored. Write only while the pipeline is empty.
//  - Reset (synchronous, rst_n low) clears all stage valid bits, drops any
//    request in flight and loads the default intrinsics.
//  - A point at the origin or with a zero denominator gives zeros and
//    valid_res low; an overflowing u or v saturates with valid_res low.
module unified_camera_project #(
  parameter int FRAC_BITS = ucp_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ucp_pkg::point_t            in_point,
  output logic                       out_strobe,
  output ucp_pkg::pixel_t            out_res,
  input  logic                       cfg_we,
  input  logic [ucp_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ucp_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CW = ucp_pkg::COORD_W;

  ucp_pkg::cfg_t cfg_r;

  // intrinsics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x   <= 29'd33554432;
      cfg_r.focal_y   <= 29'd33554432;
      cfg_r.center_x  <= 29'd20971520;
      cfg_r.center_y  <= 29'd15728640;
      cfg_r.mirror_xi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ucp_pkg::REG_FOCAL_X:  cfg_r.focal_x   <= cfg_wdata;
        ucp_pkg::REG_FOCAL_Y:  cfg_r.focal_y   <= cfg_wdata;
        ucp_pkg::REG_CENTER_X: cfg_r.center_x  <= cfg_wdata;
        ucp_pkg::REG_CENTER_Y: cfg_r.center_y  <= cfg_wdata;
        ucp_pkg::REG_MIRROR:   cfg_r.mirror_xi <= cfg_wdata[ucp_pkg::XI_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // norm stage outputs
  logic                        n_valid;
  ucp_pkg::point_t             n_point;
  logic [ucp_pkg::ROOT_W-1:0]  n_root;

  ucp_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_point  (in_point),
    .out_valid (n_valid),
    .out_point (n_point),
    .out_root  (n_root)
  );

  // divider operands
  logic                        d_valid;
  logic [ucp_pkg::NUM_W-1:0]   d_num_x, d_num_y;
  logic [ucp_pkg::DEN_W-1:0]   d_div;
  ucp_pkg::div_side_t          d_side_x, d_side_y;

  ucp_denom #(.FRAC_BITS(FRAC_BITS)) u_denom (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (n_valid),
    .in_point   (n_point),
    .in_root    (n_root),
    .cfg        (cfg_r),
    .out_valid  (d_valid),
    .out_num_x  (d_num_x),
    .out_num_y  (d_num_y),
    .out_div    (d_div),
    .out_side_x (d_side_x),
    .out_side_y (d_side_y)
  );

  // two divider lanes in lockstep; the strobe needs both lane valid bits, lane x carries the degenerate flag
  logic                        qx_valid, qy_valid;
  logic [ucp_pkg::NUM_W-1:0]   qx, qy;
  ucp_pkg::div_side_t          sx, sy;

  ucp_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_num    (d_num_x),
    .in_div    (d_div),
    .in_side   (d_side_x),
    .out_valid (qx_valid),
    .out_quot  (qx),
    .out_side  (sx)
  );

  ucp_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_num    (d_num_y),
    .in_div    (d_div),
    .in_side   (d_side_y),
    .out_valid (qy_valid),
    .out_quot  (qy),
    .out_side  (sy)
  );

  // sign, offset and saturation, then the output register
  logic [CW:0]      fin_u, fin_v;
  logic             strobe_r;
  ucp_pkg::pixel_t  res_r, res_nxt;

  assign fin_u = ucp_pkg::ucp_finish(qx, sx.neg, sx.offset);
  assign fin_v = ucp_pkg::ucp_finish(qy, sy.neg, sy.offset);

  always_comb begin
    if (sx.degen) begin
      res_nxt = '0;
    end else begin
      res_nxt.pixel_u   = fin_u[CW-1:0];
      res_nxt.pixel_v   = fin_v[CW-1:0];
      res_nxt.valid_res = !fin_u[CW] && !fin_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= qx_valid && qy_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

// ----- rtl/ucp_check.sv -----
// Port-level checker for the projection pipeline, bound to the top level.
module ucp_check (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_strobe,
  input ucp_pkg::pixel_t out_res
);

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result traces back to a request a fixed latency earlier
  a_strobe_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && rst_n, ucp_pkg::LATENCY))
    else $error("result without matching request");

  // invalid result that is not saturated must be all zeros
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.valid_res
     && out_res.pixel_u != 32'h7FFF_FFFF && out_res.pixel_u != 32'h8000_0000
     && out_res.pixel_v != 32'h7FFF_FFFF && out_res.pixel_v != 32'h8000_0000)
    |-> (out_res.pixel_u == '0 && out_res.pixel_v == '0))
    else $error("invalid result not cleared");

  // a strobed result carries fully known data
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_res))
    else $error("result with unknown bits");

endmodule

bind unified_camera_project ucp_check u_ucp_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the unified camera projection pipeline.
`timescale 1ns / 100ps

module tb_top;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  ucp_pkg::point_t           in_point = '0;
  logic                      out_strobe;
  ucp_pkg::pixel_t           out_res;
  logic                      cfg_we = 1'b0;
  logic [ucp_pkg::IDX_W-1:0] cfg_index = ucp_pkg::REG_FOCAL_X;
  logic [ucp_pkg::CFG_W-1:0] cfg_wdata = '0;

  unified_camera_project dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point(in_point), .out_strobe(out_strobe), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Local copy of the intrinsics, mirrored on every register write.
  logic [ucp_pkg::CFG_W-1:0] fx_q, fy_q, cx_q, cy_q;
  logic [ucp_pkg::XI_W-1:0]  xi_q;

  ucp_pkg::point_t pending_points[$];
  ucp_pkg::pixel_t expected_pixels[$];
  int     errors = 0;
  int     n_checked = 0;
  int     n_invalid = 0;
  int     cycle = 0;
  bit     idle_en = 1'b1;
  bit     pause_src = 1'b0;

  // Round(f*c/den) + off, clamped to signed 32 bits; ok cleared on clamp.
  function automatic logic [31:0] axis_pixel(input logic [ucp_pkg::CFG_W-1:0] f,
                                            input longint c, input longint den,
                                            input logic [ucp_pkg::CFG_W-1:0] off,
                                            inout bit ok);
    logic [63:0] nmag, dmag, q;
    longint      val;
    nmag = 64'(f) * 64'(c < 0 ? -c : c);
    dmag = 64'(den < 0 ? -den : den);
    q = (2 * nmag + dmag) / (2 * dmag);
    val = (((c < 0) != (den < 0)) && q != 0) ? -longint'(q) : longint'(q);
    val += longint'(off);
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
      ok = 1'b0;
    end else if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
      ok = 1'b0;
    end
    return val[31:0];
  endfunction

  function automatic ucp_pkg::pixel_t project_point(input ucp_pkg::point_t p);
    ucp_pkg::pixel_t r;
    longint          x, y, z, den;
    logic [63:0]     s, rem, root, bitv, xd;
    bit              ok;
    x = p.point_x;
    y = p.point_y;
    z = p.point_z;
    r = '0;
    ok = 1'b1;
    s = 64'(x * x) + 64'(y * y) + 64'(z * z);
    // bitwise integer square root, floor
    rem = s;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root == 0) return r;
    xd = (64'(xi_q) * root + (64'd1 << (ucp_pkg::FRAC_BITS_DEF - 1)))
         >> ucp_pkg::FRAC_BITS_DEF;
    den = longint'(xd) + z;
    if (den == 0) return r;
    r.pixel_u = axis_pixel(fx_q, x, den, cx_q, ok);
    r.pixel_v = axis_pixel(fy_q, y, den, cy_q, ok);
    r.valid_res = ok;
    return r;
  endfunction

  // Driver: one request per accepted edge, random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) void'(pending_points.pop_front());
      if (pending_points.size() != 0 && !pause_src
          && !(idle_en && $urandom_range(99) < 32)) begin
        start <= 1'b1;
        in_point <= pending_points[0];
      end else begin
        start <= 1'b0;
        in_point <= {3{32'($urandom)}};
      end
    end
  end

  // Predict at acceptance, so config seen is that of the request.
  always @(posedge clk) begin
    if (rst_n && start && !busy) expected_pixels.push_back(project_point(in_point));
  end

  // Monitor: results cannot be held off, check each strobe.
  always @(posedge clk) begin
    ucp_pkg::pixel_t e;
    if (rst_n && out_strobe) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result u=%0d v=%0d", out_res.pixel_u, out_res.pixel_v);
        errors++;
      end else begin
        e = expected_pixels.pop_front();
        n_checked++;
        if (!e.valid_res) n_invalid++;
        if (out_res.pixel_u !== e.pixel_u) begin
          $error("pixel_u expected %0d got %0d", e.pixel_u, out_res.pixel_u);
          errors++;
        end
        if (out_res.pixel_v !== e.pixel_v) begin
          $error("pixel_v expected %0d got %0d", e.pixel_v, out_res.pixel_v);
          errors++;
        end
        if (out_res.valid_res !== e.valid_res) begin
          $error("valid_res expected %0d got %0d", e.valid_res, out_res.valid_res);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input ucp_pkg::cfg_reg_t idx,
                           input logic [ucp_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ucp_pkg::REG_FOCAL_X:  fx_q = val;
      ucp_pkg::REG_FOCAL_Y:  fy_q = val;
      ucp_pkg::REG_CENTER_X: cx_q = val;
      ucp_pkg::REG_CENTER_Y: cy_q = val;
      ucp_pkg::REG_MIRROR:   xi_q = val[ucp_pkg::XI_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until the pipe has drained, then write the whole register set.
  task automatic load_intrinsics(input logic [ucp_pkg::CFG_W-1:0] fx, fy, cx, cy,
                                 input logic [ucp_pkg::CFG_W-1:0] xi);
    while (pending_points.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (ucp_pkg::LATENCY + 4) @(posedge clk);
    write_reg(ucp_pkg::REG_FOCAL_X, fx);
    write_reg(ucp_pkg::REG_FOCAL_Y, fy);
    write_reg(ucp_pkg::REG_CENTER_X, cx);
    write_reg(ucp_pkg::REG_CENTER_Y, cy);
    write_reg(ucp_pkg::REG_MIRROR, xi);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1, 3) == 1 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(32'h00A0_0000)) - 32'h0050_0000);
    endcase
  endfunction

  function automatic ucp_pkg::point_t rand_point();
    ucp_pkg::point_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    // mostly in front of the camera
    p.point_z = ($urandom_range(3) != 0) ? 32'($urandom_range(32'h00FF_0000, 32'h1000))
                                         : rand_coord();
    return p;
  endfunction

  initial begin
    fx_q = 29'd33554432;
    fy_q = 29'd33554432;
    cx_q = 29'd20971520;
    cy_q = 29'd15728640;
    xi_q = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: origin, zero denominator, extremes, negative z.
    pending_points.push_back('{32'sd0, 32'sd0, 32'sd0});
    pending_points.push_back('{32'sd65536, 32'sd0, 32'sd0});          // den zero at xi=0
    pending_points.push_back('{32'sd65536, -32'sd65536, 32'sd65536});
    pending_points.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sd1});  // saturate high
    pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'sd1});  // saturate low
    pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_points.push_back('{32'sd1, -32'sd1, -32'sd65536});         // negative den
    pending_points.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF});
    pending_points.push_back('{32'sd3, 32'sd5, 32'sd2});               // small coordinates
    pending_points.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000});

    // xi = 1.0: point with z = -xi*d gives a zero denominator (d = 1.0 * 2^16).
    load_intrinsics(29'h1FFF_FFFF, 29'd0, 29'h1FFF_FFFF, 29'd0, 29'd65536);
    pending_points.push_back('{32'sd0, 32'sd0, -32'sd65536});          // origin-free, den = d + z = 0
    pending_points.push_back('{32'sd0, 32'sd65536, 32'sd0});
    pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_points.push_back('{-32'sd5, 32'sd7, 32'sd1});
    load_intrinsics(29'd0, 29'h1FFF_FFFF, 29'd0, 29'h1FFF_FFFF, 29'h3FFFF);
    pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_points.push_back('{32'sd100, -32'sd100, 32'sd0});
    pending_points.push_back('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000});

    // Random phases with fresh intrinsics; one phase without idling.
    for (int ph = 0; ph < 5; ph++) begin
      load_intrinsics(29'($urandom_range(29'd268435456)),
                      29'($urandom_range(29'd268435456)),
                      29'($urandom_range(29'd268435456)),
                      29'($urandom_range(29'd268435456)),
                      29'($urandom_range(262144)));
      idle_en = (ph != 2);
      for (int i = 0; i < 100; i++) pending_points.push_back(rand_point());
      if (ph == 3) begin
        // hold the sender until everything in flight has come out
        while (pending_points.size() > 50) @(posedge clk);
        pause_src = 1'b1;
        while (expected_pixels.size() != 0) @(posedge clk);
        pause_src = 1'b0;
      end
    end
    while (pending_points.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (ucp_pkg::LATENCY + 10) @(posedge clk);
    $display("Checked %0d projections (%0d degenerate or saturated) over 8 intrinsics sets.",
             n_checked, n_invalid);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ucp_pkg.sv
rtl/ucp_norm.sv
rtl/ucp_denom.sv
rtl/ucp_div.sv
rtl/unified_camera_project.sv
rtl/ucp_check.sv
sim/tb_top.sv
